@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ hw/rtl/pwcs_pkg.sv @@
// Types and constants of the pulse width command sender.
package pwcs_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_PRE   = 3'd1,
    PH_SLOW  = 3'd2,
    PH_BHIGH = 3'd3,
    PH_BLOW  = 3'd4,
    PH_CLOSE = 3'd5,
    PH_GAP   = 3'd6
  } phase_t;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam int CfgIndexWidth = 2;
  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_REPEAT_COUNT    = 2'd0,
    CFG_GAP_TICKS       = 2'd1,
    CFG_START_LOW_TICKS = 2'd2
  } cfg_index_t;

  localparam int CfgDataWidth = 16;

  localparam logic [3:0]  REPEAT_COUNT_RST    = 4'd3;
  localparam logic [15:0] GAP_TICKS_RST       = 16'd0;
  localparam logic [7:0]  START_LOW_TICKS_RST = 8'd16;

  typedef struct packed {
    logic       kind;
    logic [3:0] command;
  } in_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic all_done;
    logic start_rejected;
  } out_item_t;

endpackage

@@ hw/rtl/pulse_width_command_sender.sv @@
// Pulse width command sender: sequencer for a one-wire command line.
//
// Each input transfer is either a base-time tick or a start with a 4-bit
// command; each produces exactly one result transfer. A start builds the byte
// {~command, command} and sends it repeat_count times as: one high tick, a
// low start pulse of start_low_ticks ticks, 8 bits LSB first (high one tick,
// then low one tick for a 0 or two for a 1), a closing high tick and
// gap_ticks high ticks. A start while busy is dropped and flagged. The
// sequencer updates its state once per accepted item, so the block takes one
// item every clock while in_ready is high; the result is registered. A
// two-entry output buffer (output register plus skid register) lets input
// keep flowing while a result waits; input stalls only when both are full.
// Configuration is written through cfg_valid/cfg_index/cfg_data, always ready.
`include "assert_macros.svh"

module pulse_width_command_sender (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  pwcs_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output pwcs_pkg::out_item_t                    out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pwcs_pkg::CfgIndexWidth-1:0]     cfg_index,
  input  logic [pwcs_pkg::CfgDataWidth-1:0]      cfg_data
);

  // configuration registers
  logic [3:0]  repeat_count;
  logic [15:0] gap_ticks;
  logic [7:0]  start_low_ticks;

  // sequencer state
  pwcs_pkg::phase_t phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [7:0]  frame_byte, frame_byte_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [3:0]  repeats_left, repeats_left_next;
  logic        line_reg, line_reg_next;

  // output buffer
  pwcs_pkg::out_item_t skid_data;
  logic                skid_valid;
  pwcs_pkg::out_item_t result;

  logic        in_fire;
  logic        out_fire;
  logic [15:0] tick_dec;
  logic        gap_end;
  logic        done;
  logic        rejected;

  assign in_ready  = !skid_valid;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign tick_dec  = tick_count - 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_count    <= pwcs_pkg::REPEAT_COUNT_RST;
      gap_ticks       <= pwcs_pkg::GAP_TICKS_RST;
      start_low_ticks <= pwcs_pkg::START_LOW_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pwcs_pkg::CFG_REPEAT_COUNT:    repeat_count    <= cfg_data[3:0];
        pwcs_pkg::CFG_GAP_TICKS:       gap_ticks       <= cfg_data;
        pwcs_pkg::CFG_START_LOW_TICKS: start_low_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    frame_byte_next   = frame_byte;
    bit_index_next    = bit_index;
    repeats_left_next = repeats_left;
    line_reg_next     = line_reg;
    gap_end           = 1'b0;
    done              = 1'b0;
    rejected          = 1'b0;

    if (in_data.kind == pwcs_pkg::KIND_START) begin
      if (phase != pwcs_pkg::PH_IDLE) begin
        rejected = 1'b1;
      end else if (repeat_count != 4'd0) begin
        frame_byte_next   = {~in_data.command, in_data.command};
        repeats_left_next = repeat_count;
        bit_index_next    = 3'd0;
        tick_count_next   = 16'd0;
        phase_next        = pwcs_pkg::PH_PRE;
        line_reg_next     = 1'b1;
      end
    end else begin
      unique case (phase)
        pwcs_pkg::PH_IDLE: ;
        pwcs_pkg::PH_PRE: begin
          bit_index_next = 3'd0;
          if (start_low_ticks == 8'd0) begin
            phase_next    = pwcs_pkg::PH_BHIGH;
            line_reg_next = 1'b1;
          end else begin
            phase_next      = pwcs_pkg::PH_SLOW;
            tick_count_next = {8'd0, start_low_ticks};
            line_reg_next   = 1'b0;
          end
        end
        pwcs_pkg::PH_SLOW: begin
          tick_count_next = tick_dec;
          if (tick_dec == 16'd0) begin
            phase_next    = pwcs_pkg::PH_BHIGH;
            line_reg_next = 1'b1;
          end
        end
        pwcs_pkg::PH_BHIGH: begin
          phase_next      = pwcs_pkg::PH_BLOW;
          tick_count_next = {15'd0, frame_byte[bit_index]} + 16'd1;
          line_reg_next   = 1'b0;
        end
        pwcs_pkg::PH_BLOW: begin
          tick_count_next = tick_dec;
          if (tick_dec == 16'd0) begin
            line_reg_next = 1'b1;
            if (bit_index == 3'd7) begin
              phase_next = pwcs_pkg::PH_CLOSE;
            end else begin
              bit_index_next = bit_index + 3'd1;
              phase_next     = pwcs_pkg::PH_BHIGH;
            end
          end
        end
        pwcs_pkg::PH_CLOSE: begin
          line_reg_next = 1'b1;
          if (gap_ticks == 16'd0) begin
            gap_end = 1'b1;
          end else begin
            phase_next      = pwcs_pkg::PH_GAP;
            tick_count_next = gap_ticks;
          end
        end
        pwcs_pkg::PH_GAP: begin
          tick_count_next = tick_dec;
          if (tick_dec == 16'd0) gap_end = 1'b1;
        end
        default: begin
          phase_next    = pwcs_pkg::PH_IDLE;
          line_reg_next = 1'b1;
        end
      endcase

      // end of one frame's gap: repeat or finish
      if (gap_end) begin
        line_reg_next = 1'b1;
        if (repeats_left <= 4'd1) begin
          repeats_left_next = 4'd0;
          phase_next        = pwcs_pkg::PH_IDLE;
          done              = 1'b1;
        end else begin
          repeats_left_next = repeats_left - 4'd1;
          phase_next        = pwcs_pkg::PH_PRE;
        end
      end
    end

    result.line_level     = line_reg_next;
    result.busy_res       = (phase_next != pwcs_pkg::PH_IDLE);
    result.all_done       = done;
    result.start_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= pwcs_pkg::PH_IDLE;
      tick_count   <= 16'd0;
      frame_byte   <= 8'd0;
      bit_index    <= 3'd0;
      repeats_left <= 4'd0;
      line_reg     <= 1'b1;
    end else if (in_fire) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      frame_byte   <= frame_byte_next;
      bit_index    <= bit_index_next;
      repeats_left <= repeats_left_next;
      line_reg     <= line_reg_next;
    end
  end

  // output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end else if (out_fire && skid_valid) begin
      out_data <= skid_data;
    end
  end

  `ASSERT_ALWAYS(a_skid_behind_out, clk, rst, skid_valid |-> out_valid)
  `ASSERT_NEVER(a_idle_line_high, clk, rst, (phase == pwcs_pkg::PH_IDLE) && !line_reg)
  `ASSERT_NEVER(a_busy_has_repeats, clk, rst, (phase != pwcs_pkg::PH_IDLE) && (repeats_left == 4'd0))
  `ASSERT_ALWAYS(a_reject_keeps_state, clk, rst, (in_fire && (in_data.kind == pwcs_pkg::KIND_START) && (phase != pwcs_pkg::PH_IDLE)) |=> ($stable(phase) && $stable(repeats_left) && $stable(line_reg)))

endmodule

@@ sim/pulse_width_command_sender_test.sv @@
// Testbench for the pulse width command sender: directed table plus random frames.
`timescale 1ns / 1ps

module pulse_width_command_sender_test;

  localparam int HOLD_CYCLES = 300;
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int SETTING_COUNT = 5;

  typedef enum {ROW_ITEM, ROW_CFG} row_op_t;
  typedef enum {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

  typedef struct {
    row_op_t              op;
    logic                 kind;
    logic [3:0]           cmd;
    int                   reps;
    logic                 fixed;
    pwcs_pkg::out_item_t  want;
    pwcs_pkg::cfg_index_t idx;
    logic [15:0]          val;
  } dir_row_t;

  typedef struct {
    logic        load;
    logic [3:0]  rep;
    logic [15:0] gap;
    logic [7:0]  slow;
    pace_t       pace;
    int          items;
  } line_setting_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pwcs_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pwcs_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pwcs_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [pwcs_pkg::CfgDataWidth-1:0] cfg_data = '0;

  // Predictor state and its copy of the registers
  pwcs_pkg::phase_t pr_phase;
  logic [15:0] pr_ticks;
  logic [7:0]  pr_byte;
  logic [2:0]  pr_bit;
  logic [3:0]  pr_left;
  logic        pr_line;
  logic [3:0]  cf_repeat;
  logic [15:0] cf_gap;
  logic [7:0]  cf_slow;

  pwcs_pkg::out_item_t line_expect_q[$];
  pwcs_pkg::out_item_t want_now;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int hold_asked = 0;
  int hold_served = 0;

  // Columns: op, kind, command, repeats, fixed, want {line,busy,done,rej}, register, value
  dir_row_t dir_rows [11] = '{
    '{ROW_ITEM, pwcs_pkg::KIND_TICK, 4'h0, 1, 1'b1, 4'b1000, pwcs_pkg::CFG_REPEAT_COUNT, 16'd0},
    '{ROW_ITEM, pwcs_pkg::KIND_TICK, 4'hf, 1, 1'b1, 4'b1000, pwcs_pkg::CFG_REPEAT_COUNT, 16'd0},
    '{ROW_CFG, pwcs_pkg::KIND_TICK, 4'h0, 0, 1'b0, 4'b0000, pwcs_pkg::CFG_REPEAT_COUNT, 16'd0},
    '{ROW_ITEM, pwcs_pkg::KIND_START, 4'hf, 1, 1'b1, 4'b1000, pwcs_pkg::CFG_REPEAT_COUNT, 16'd0},
    '{ROW_CFG, pwcs_pkg::KIND_TICK, 4'h0, 0, 1'b0, 4'b0000, pwcs_pkg::CFG_REPEAT_COUNT, 16'd1},
    '{ROW_CFG, pwcs_pkg::KIND_TICK, 4'h0, 0, 1'b0, 4'b0000, pwcs_pkg::CFG_GAP_TICKS, 16'd0},
    '{ROW_CFG, pwcs_pkg::KIND_TICK, 4'h0, 0, 1'b0, 4'b0000, pwcs_pkg::CFG_START_LOW_TICKS, 16'd0},
    '{ROW_ITEM, pwcs_pkg::KIND_START, 4'h0, 1, 1'b1, 4'b1100, pwcs_pkg::CFG_REPEAT_COUNT, 16'd0},
    '{ROW_ITEM, pwcs_pkg::KIND_START, 4'hf, 1, 1'b1, 4'b1101, pwcs_pkg::CFG_REPEAT_COUNT, 16'd0},
    '{ROW_ITEM, pwcs_pkg::KIND_TICK, 4'h9, 21, 1'b0, 4'b0000, pwcs_pkg::CFG_REPEAT_COUNT, 16'd0},
    '{ROW_ITEM, pwcs_pkg::KIND_TICK, 4'hf, 1, 1'b1, 4'b1010, pwcs_pkg::CFG_REPEAT_COUNT, 16'd0}
  };

  line_setting_t settings [SETTING_COUNT] = '{
    '{1'b0, 4'd3,  16'd0,     8'd16,  PACE_SLOW_SINK,   60},
    '{1'b1, 4'd2,  16'd1,     8'd1,   PACE_SLOW_SINK,   50},
    '{1'b1, 4'd1,  16'd5,     8'd255, PACE_SLOW_SOURCE, 10},
    '{1'b1, 4'd0,  16'd7,     8'd4,   PACE_SLOW_SOURCE, 20},
    '{1'b1, 4'd2,  16'd2,     8'd3,   PACE_FULL,        40}
  };

  pulse_width_command_sender u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Close one frame; return 1 when the last repeat is done
  function automatic logic finish_frame();
    pr_line = 1'b1;
    if (pr_left <= 4'd1) begin
      pr_left = 4'd0;
      pr_phase = pwcs_pkg::PH_IDLE;
      return 1'b1;
    end
    pr_left = pr_left - 4'd1;
    pr_phase = pwcs_pkg::PH_PRE;
    return 1'b0;
  endfunction

  function automatic pwcs_pkg::out_item_t advance_line(input pwcs_pkg::in_item_t item);
    pwcs_pkg::out_item_t res;
    logic done;
    logic rejected;
    done = 1'b0;
    rejected = 1'b0;
    if (item.kind == pwcs_pkg::KIND_START) begin
      if (pr_phase != pwcs_pkg::PH_IDLE) begin
        rejected = 1'b1;
      end else if (cf_repeat != 4'd0) begin
        pr_byte = {~item.command, item.command};
        pr_left = cf_repeat;
        pr_bit = 3'd0;
        pr_ticks = 16'd0;
        pr_phase = pwcs_pkg::PH_PRE;
        pr_line = 1'b1;
      end
    end else begin
      case (pr_phase)
        pwcs_pkg::PH_PRE: begin
          pr_bit = 3'd0;
          if (cf_slow == 8'd0) begin
            pr_phase = pwcs_pkg::PH_BHIGH;
            pr_line = 1'b1;
          end else begin
            pr_phase = pwcs_pkg::PH_SLOW;
            pr_ticks = {8'd0, cf_slow};
            pr_line = 1'b0;
          end
        end
        pwcs_pkg::PH_SLOW: begin
          pr_ticks = pr_ticks - 16'd1;
          if (pr_ticks == 16'd0) begin
            pr_phase = pwcs_pkg::PH_BHIGH;
            pr_line = 1'b1;
          end
        end
        pwcs_pkg::PH_BHIGH: begin
          pr_phase = pwcs_pkg::PH_BLOW;
          pr_ticks = 16'd1 + {15'd0, pr_byte[pr_bit]};
          pr_line = 1'b0;
        end
        pwcs_pkg::PH_BLOW: begin
          pr_ticks = pr_ticks - 16'd1;
          if (pr_ticks == 16'd0) begin
            pr_line = 1'b1;
            if (pr_bit == 3'd7) begin
              pr_phase = pwcs_pkg::PH_CLOSE;
            end else begin
              pr_bit = pr_bit + 3'd1;
              pr_phase = pwcs_pkg::PH_BHIGH;
            end
          end
        end
        pwcs_pkg::PH_CLOSE: begin
          pr_line = 1'b1;
          if (cf_gap == 16'd0) begin
            done = finish_frame();
          end else begin
            pr_phase = pwcs_pkg::PH_GAP;
            pr_ticks = cf_gap;
          end
        end
        pwcs_pkg::PH_GAP: begin
          pr_ticks = pr_ticks - 16'd1;
          if (pr_ticks == 16'd0) done = finish_frame();
        end
        default: begin
          pr_phase = pwcs_pkg::PH_IDLE;
          pr_line = 1'b1;
        end
      endcase
    end
    res.line_level = pr_line;
    res.busy_res = (pr_phase != pwcs_pkg::PH_IDLE);
    res.all_done = done;
    res.start_rejected = rejected;
    return res;
  endfunction

  task automatic note_failure(input string what);
    errors++;
    if (errors <= 10) $display("%s", what);
  endtask

  // Offer one item and hold it until the transfer; return at the accepting edge
  task automatic send_item(input pwcs_pkg::in_item_t item, input logic fixed,
                           input pwcs_pkg::out_item_t want);
    pwcs_pkg::out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_line(item);
    line_expect_q.push_back(fixed ? want : predicted);
  endtask

  task automatic write_reg(input pwcs_pkg::cfg_index_t idx, input logic [15:0] val);
    in_valid <= 1'b0;
    do @(posedge clk); while (line_expect_q.size() != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      pwcs_pkg::CFG_REPEAT_COUNT:    cf_repeat = val[3:0];
      pwcs_pkg::CFG_GAP_TICKS:       cf_gap = val;
      pwcs_pkg::CFG_START_LOW_TICKS: cf_slow = val[7:0];
      default: ;
    endcase
  endtask

  function automatic void set_pace(input pace_t pace);
    case (pace)
      PACE_SLOW_SINK: begin
        send_idle_pct = 10;
        recv_idle_pct = 78;
      end
      PACE_SLOW_SOURCE: begin
        send_idle_pct = 78;
        recv_idle_pct = 10;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endfunction

  // Receiver: random back-pressure, plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (line_expect_q.size() == 0) begin
        note_failure($sformatf("unexpected result at %0t: line=%0b busy=%0b done=%0b rej=%0b",
                               $realtime, out_data.line_level, out_data.busy_res,
                               out_data.all_done, out_data.start_rejected));
      end else begin
        want_now = line_expect_q.pop_front();
        if (want_now.line_level !== out_data.line_level ||
            want_now.busy_res !== out_data.busy_res ||
            want_now.all_done !== out_data.all_done ||
            want_now.start_rejected !== out_data.start_rejected) begin
          note_failure($sformatf({"mismatch at %0t: expected line=%0b busy=%0b done=%0b ",
                                  "rej=%0b, got line=%0b busy=%0b done=%0b rej=%0b"},
                                 $realtime, want_now.line_level, want_now.busy_res,
                                 want_now.all_done, want_now.start_rejected,
                                 out_data.line_level, out_data.busy_res,
                                 out_data.all_done, out_data.start_rejected));
        end
      end
    end
  end

  initial begin : stimulus
    pwcs_pkg::in_item_t item;
    int r;
    int n;
    pr_phase = pwcs_pkg::PH_IDLE;
    pr_ticks = '0;
    pr_byte = '0;
    pr_bit = '0;
    pr_left = '0;
    pr_line = 1'b1;
    cf_repeat = pwcs_pkg::REPEAT_COUNT_RST;
    cf_gap = pwcs_pkg::GAP_TICKS_RST;
    cf_slow = pwcs_pkg::START_LOW_TICKS_RST;
    set_pace(PACE_SLOW_SINK);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        for (r = 0; r < dir_rows[i].reps; r++) begin
          item.kind = dir_rows[i].kind;
          item.command = dir_rows[i].cmd;
          send_item(item, dir_rows[i].fixed, dir_rows[i].want);
        end
      end
    end

    for (int s = 0; s < SETTING_COUNT; s++) begin
      set_pace(settings[s].pace);
      if (settings[s].load) begin
        write_reg(pwcs_pkg::CFG_REPEAT_COUNT, {12'd0, settings[s].rep});
        write_reg(pwcs_pkg::CFG_GAP_TICKS, settings[s].gap);
        write_reg(pwcs_pkg::CFG_START_LOW_TICKS, {8'd0, settings[s].slow});
      end
      n = 0;
      // Run whole commands: mostly starts when idle, mostly ticks while busy
      while (n < settings[s].items || pr_phase != pwcs_pkg::PH_IDLE) begin
        if (pr_phase == pwcs_pkg::PH_IDLE)
          item.kind = ($urandom_range(9) != 0) ? pwcs_pkg::KIND_START : pwcs_pkg::KIND_TICK;
        else
          item.kind = ($urandom_range(19) == 0) ? pwcs_pkg::KIND_START : pwcs_pkg::KIND_TICK;
        item.command = 4'($urandom_range(15));
        send_item(item, 1'b0, '0);
        n++;
        if (s == 0 && n == 60) begin
          // drain everything before going on
          in_valid <= 1'b0;
          do @(posedge clk); while (line_expect_q.size() != 0);
        end
        if (s == 1 && n == 40) hold_asked <= hold_asked + 1;
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (line_expect_q.size() != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT_NS;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/pwcs_pkg.sv
hw/rtl/pulse_width_command_sender.sv
sim/pulse_width_command_sender_test.sv
